@@ hw/rtl/smsd_pkg.sv @@
package smsd_pkg;

  // Default burst length.
  localparam int SAMPLES_DEF = 16;

  // Converter sample width.
  localparam int SAMPLE_BITS = 10;

  // Multiplier digit width of the per-sample squaring step.
  localparam int DIGIT_W = 3;

  // Reference voltage register.
  localparam int VREF_W = 13;
  localparam logic [VREF_W-1:0] VREF_RESET = 13'd3300;

  // Converter full-scale code and its width.
  localparam int FULL_SCALE = 1023;
  localparam int FS_W = 10;

  // Result field widths.
  localparam int MEAN_W = 14;
  localparam int SIGMA_W = 14;
  localparam int LEVEL_W = 13;

  // Status of one of the serial arithmetic units.
  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

endpackage

@@ hw/rtl/smsd_acc.sv @@
module smsd_acc #(
  parameter int SAMPLES = smsd_pkg::SAMPLES_DEF
) (
  input  logic                                                   clk,
  input  logic                                                   rst_n,
  input  logic                                                   in_valid,
  output logic                                                   in_ready,
  input  logic [smsd_pkg::SAMPLE_BITS-1:0]                       in_sample,
  output logic                                                   tot_valid,
  input  logic                                                   tot_ready,
  output logic [smsd_pkg::SAMPLE_BITS+$clog2(SAMPLES+1)-1:0]     tot_sum,
  output logic [2*smsd_pkg::SAMPLE_BITS+$clog2(SAMPLES+1)-1:0]   tot_sum_sq
);
  import smsd_pkg::*;

  localparam int NW = $clog2(SAMPLES + 1);
  localparam int SUM_W = SAMPLE_BITS + NW;
  localparam int SQ_W = 2 * SAMPLE_BITS + NW;
  localparam int NDIG = (SAMPLE_BITS + DIGIT_W - 1) / DIGIT_W;
  localparam int XP_W = NDIG * DIGIT_W;
  localparam int MC_W = SAMPLE_BITS + DIGIT_W * (NDIG - 1);
  localparam int PP_W = MC_W + DIGIT_W;
  localparam int CNT_W = $clog2(SAMPLES);
  localparam int DC_W = $clog2(NDIG);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SAMPLES - 1);
  localparam logic [DC_W-1:0] DC_LAST = DC_W'(NDIG - 1);

  logic [XP_W-1:0]  x_r, x_nxt;
  logic [MC_W-1:0]  mc_r, mc_nxt;
  logic [DC_W-1:0]  dc_r, dc_nxt;
  logic             busy_r, busy_nxt;
  logic             last_r, last_nxt;
  logic             pend_r, pend_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [SQ_W-1:0]  sq_r, sq_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             fin;
  logic             accept;
  logic [PP_W-1:0]  pp;

  // A new sample may enter in the cycle that retires the last digit of the previous one.
  assign fin = busy_r && (dc_r == DC_LAST);
  assign in_ready = !pend_r && (!busy_r || (fin && !last_r));
  assign accept = in_valid && in_ready;

  // Partial product of the low multiplier digit and the shifted multiplicand.
  assign pp = PP_W'(x_r[DIGIT_W-1:0]) * PP_W'(mc_r);

  assign tot_valid = pend_r;
  assign tot_sum = sum_r;
  assign tot_sum_sq = sq_r;

  // Digit-serial squaring into the sum of squares, and burst bookkeeping.
  always_comb begin
    x_nxt = x_r;
    mc_nxt = mc_r;
    dc_nxt = dc_r;
    busy_nxt = busy_r;
    last_nxt = last_r;
    pend_nxt = pend_r;
    sum_nxt = sum_r;
    sq_nxt = sq_r;
    cnt_nxt = cnt_r;
    if (busy_r) begin
      sq_nxt = sq_r + SQ_W'(pp);
      x_nxt = x_r >> DIGIT_W;
      mc_nxt = mc_r << DIGIT_W;
      dc_nxt = dc_r + 1'b1;
      if (fin) begin
        busy_nxt = 1'b0;
        if (last_r) begin
          pend_nxt = 1'b1;
        end
      end
    end
    if (accept) begin
      x_nxt = XP_W'(in_sample);
      mc_nxt = MC_W'(in_sample);
      dc_nxt = '0;
      busy_nxt = 1'b1;
      sum_nxt = sum_r + SUM_W'(in_sample);
      last_nxt = (cnt_r == CNT_LAST);
      cnt_nxt = (cnt_r == CNT_LAST) ? '0 : cnt_r + 1'b1;
    end
    // Hand the burst totals over and start the next burst from zero.
    if (pend_r && tot_ready) begin
      pend_nxt = 1'b0;
      sum_nxt = '0;
      sq_nxt = '0;
    end
  end

  // Control and accumulator state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dc_r <= '0;
      busy_r <= 1'b0;
      last_r <= 1'b0;
      pend_r <= 1'b0;
      sum_r <= '0;
      sq_r <= '0;
      cnt_r <= '0;
    end else begin
      dc_r <= dc_nxt;
      busy_r <= busy_nxt;
      last_r <= last_nxt;
      pend_r <= pend_nxt;
      sum_r <= sum_nxt;
      sq_r <= sq_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Operand shift registers.
  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    mc_r <= mc_nxt;
  end

endmodule

@@ hw/rtl/smsd_mul.sv @@
module smsd_mul #(
  parameter int AW = 25,
  parameter int BW = 15
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [AW-1:0]       a,
  input  logic [BW-1:0]       b,
  output smsd_pkg::unit_sts_t sts,
  output logic [AW+BW-1:0]    prod
);
  import smsd_pkg::*;

  localparam int CW = $clog2(BW);
  localparam logic [CW-1:0] CNT_LAST = CW'(BW - 1);

  logic [AW-1:0]    a_r, a_nxt;
  logic [AW+BW-1:0] p_r, p_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [AW:0]      hi_sum;

  // One multiplier bit per cycle: add into the upper half, then shift right.
  assign hi_sum = {1'b0, p_r[AW+BW-1:BW]} + (p_r[0] ? {1'b0, a_r} : '0);

  always_comb begin
    a_nxt = a_r;
    p_nxt = p_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      a_nxt = a;
      p_nxt = {AW'(0), b};
      cnt_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      p_nxt = {hi_sum, p_r[BW-1:1]};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r <= a_nxt;
    p_r <= p_nxt;
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign prod = p_r;

endmodule

@@ hw/rtl/smsd_div.sv @@
module smsd_div #(
  parameter int DNW = 38,
  parameter int DVW = 15
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [DNW-1:0]      dividend,
  input  logic [DVW-1:0]      divisor,
  output smsd_pkg::unit_sts_t sts,
  output logic [DNW-1:0]      quotient
);
  import smsd_pkg::*;

  localparam int CW = $clog2(DNW);
  localparam logic [CW-1:0] CNT_LAST = CW'(DNW - 1);

  logic [DVW-1:0] d_r, d_nxt;
  logic [DVW-1:0] rem_r, rem_nxt;
  logic [DNW-1:0] q_r, q_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           busy_r, busy_nxt;
  logic           done_r, done_nxt;
  logic [DVW:0]   trial;
  logic [DVW:0]   diff;
  logic           ge;

  // Restoring step: bring down one dividend bit, subtract the divisor if it fits.
  assign trial = {rem_r, q_r[DNW-1]};
  assign diff = trial - {1'b0, d_r};
  assign ge = (trial >= {1'b0, d_r});

  always_comb begin
    d_nxt = d_r;
    rem_nxt = rem_r;
    q_nxt = q_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      d_nxt = divisor;
      rem_nxt = '0;
      q_nxt = dividend;
      cnt_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[DVW-1:0] : trial[DVW-1:0];
      q_nxt = {q_r[DNW-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    d_r <= d_nxt;
    rem_r <= rem_nxt;
    q_r <= q_nxt;
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign quotient = q_r;

endmodule

@@ hw/rtl/smsd_sqrt.sv @@
module smsd_sqrt #(
  parameter int RW = 19
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [2*RW-1:0]     radicand,
  output smsd_pkg::unit_sts_t sts,
  output logic [RW-1:0]       root
);
  import smsd_pkg::*;

  localparam int CW = $clog2(RW);
  localparam logic [CW-1:0] CNT_LAST = CW'(RW - 1);

  logic [2*RW-1:0] rad_r, rad_nxt;
  logic [RW-1:0]   rem_r, rem_nxt;
  logic [RW-1:0]   root_r, root_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  logic [RW+1:0]   r2;
  logic [RW+1:0]   trial;
  logic            ge;

  // One root bit per cycle: bring down two radicand bits, try 4*root+1.
  // Before the last step the remainder stays below 2^RW, so RW bits hold it.
  assign r2 = {rem_r, rad_r[2*RW-1 -: 2]};
  assign trial = {root_r, 2'b01};
  assign ge = (r2 >= trial);

  always_comb begin
    rad_nxt = rad_r;
    rem_nxt = rem_r;
    root_nxt = root_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rad_nxt = radicand;
      rem_nxt = '0;
      root_nxt = '0;
      cnt_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rad_nxt = rad_r << 2;
      rem_nxt = ge ? RW'(r2 - trial) : RW'(r2);
      root_nxt = {root_r[RW-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rad_r <= rad_nxt;
    rem_r <= rem_nxt;
    root_r <= root_nxt;
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign root = root_r;

endmodule

@@ hw/rtl/sample_mean_stddev.sv @@
// Burst statistics of converter samples.
// Input: in_valid/in_ready with in_sample. Every SAMPLES accepted samples form a burst.
// Output: out_valid/out_ready with one request per burst: the mean with four fraction
// bits, the sample standard deviation with four fraction bits (floor root), and the
// mean in millivolts scaled by the vref register (cfg_wr_en/cfg_wr_data, reset 3300).
// Collection: a sample occupies the squaring multiplier while its 10 bits are taken
// 3 bits a cycle; the next sample of the burst may enter in the cycle that retires the last digit.
// Per burst the result engine runs three bit-serial products, three restoring
// divisions and a square root on one-bit-per-cycle units (multiplier and divider shared).
// It overlaps with collection of the next burst; when the next burst is complete
// before the engine is free, in_ready stays low until the totals are handed over.
// A result waits in the output register while out_ready is low; the engine then
// holds its finished result and the next burst's collection continues.
// Reset (synchronous, active low) empties the burst, drops any pending result
// and restores the reference voltage register.
module sample_mean_stddev #(
  parameter int SAMPLES = smsd_pkg::SAMPLES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [smsd_pkg::SAMPLE_BITS-1:0]  in_sample,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [smsd_pkg::MEAN_W-1:0]       out_mean_x16,
  output logic [smsd_pkg::SIGMA_W-1:0]      out_sigma_x16,
  output logic [smsd_pkg::LEVEL_W-1:0]      out_level_mv,
  input  logic                              cfg_wr_en,
  input  logic [smsd_pkg::VREF_W-1:0]       cfg_wr_data
);
  import smsd_pkg::*;

  localparam int NW = $clog2(SAMPLES + 1);
  localparam int SUM_W = SAMPLE_BITS + NW;
  localparam int SQ_W = 2 * SAMPLE_BITS + NW;
  localparam int SPR_W = SQ_W + NW;
  localparam int MA_W = SQ_W;
  localparam int MB_W = (SUM_W > VREF_W) ? SUM_W : VREF_W;
  localparam int LN_W = VREF_W + SUM_W;
  localparam int DN_W = (SPR_W + 8 > LN_W) ? SPR_W + 8 : LN_W;
  localparam int DV_W = (2 * NW > FS_W + NW) ? 2 * NW : FS_W + NW;
  localparam int RT_W = (DN_W + 1) / 2;
  localparam int RAD_W = 2 * RT_W;

  localparam logic [DV_W-1:0] DIV_MEAN = DV_W'(SAMPLES);
  localparam logic [DV_W-1:0] DIV_VAR = DV_W'(SAMPLES * (SAMPLES - 1));
  localparam logic [DV_W-1:0] DIV_LVL = DV_W'(FULL_SCALE * SAMPLES);
  localparam logic [MB_W-1:0] N_MULT = MB_W'(SAMPLES);
  localparam logic [MEAN_W-1:0] MEAN_MAX = {MEAN_W{1'b1}};
  localparam logic [SIGMA_W-1:0] SIGMA_MAX = {SIGMA_W{1'b1}};
  localparam logic [LEVEL_W-1:0] LEVEL_MAX = {LEVEL_W{1'b1}};

  typedef enum logic [3:0] {
    S_IDLE,
    S_SUM2,
    S_NSQ,
    S_VS,
    S_DMEAN,
    S_DVAR,
    S_DLVL,
    S_ROOT,
    S_OUT
  } seq_state_t;

  seq_state_t state_r, state_nxt;
  logic       launched_r, launched_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [MEAN_W-1:0]  out_mean_r, out_mean_nxt;
  logic [SIGMA_W-1:0] out_sigma_r, out_sigma_nxt;
  logic [LEVEL_W-1:0] out_level_r, out_level_nxt;

  logic [VREF_W-1:0]  vref_r;
  logic [SUM_W-1:0]   tsum_r, tsum_nxt;
  logic [SQ_W-1:0]    tsq_r, tsq_nxt;
  logic [SPR_W-1:0]   sum2_r, sum2_nxt;
  logic [SPR_W-1:0]   spread_r, spread_nxt;
  logic [LN_W-1:0]    lnum_r, lnum_nxt;
  logic [DN_W-1:0]    var_r, var_nxt;
  logic [MEAN_W-1:0]  res_mean_r, res_mean_nxt;
  logic [SIGMA_W-1:0] res_sigma_r, res_sigma_nxt;
  logic [LEVEL_W-1:0] res_level_r, res_level_nxt;

  logic             tot_valid;
  logic             tot_ready;
  logic [SUM_W-1:0] tot_sum;
  logic [SQ_W-1:0]  tot_sum_sq;

  logic               mul_start;
  logic [MA_W-1:0]    mul_a;
  logic [MB_W-1:0]    mul_b;
  unit_sts_t          mul_sts;
  logic [MA_W+MB_W-1:0] mul_prod;

  logic               div_start;
  logic [DN_W-1:0]    div_n;
  logic [DV_W-1:0]    div_d;
  unit_sts_t          div_sts;
  logic [DN_W-1:0]    div_q;

  logic               sqrt_start;
  unit_sts_t          sqrt_sts;
  logic [RT_W-1:0]    sqrt_root;

  // Sample collection with digit-serial squaring.
  smsd_acc #(
    .SAMPLES(SAMPLES)
  ) u_acc (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_sample  (in_sample),
    .tot_valid  (tot_valid),
    .tot_ready  (tot_ready),
    .tot_sum    (tot_sum),
    .tot_sum_sq (tot_sum_sq)
  );

  // Shared bit-serial multiplier.
  smsd_mul #(
    .AW(MA_W),
    .BW(MB_W)
  ) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .sts   (mul_sts),
    .prod  (mul_prod)
  );

  // Shared restoring divider.
  smsd_div #(
    .DNW(DN_W),
    .DVW(DV_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_n),
    .divisor  (div_d),
    .sts      (div_sts),
    .quotient (div_q)
  );

  // Bit-serial floor square root of the scaled variance.
  smsd_sqrt #(
    .RW(RT_W)
  ) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sqrt_start),
    .radicand (RAD_W'(var_r)),
    .sts      (sqrt_sts),
    .root     (sqrt_root)
  );

  // Result sequencer: each step launches one unit and waits for its done pulse.
  always_comb begin
    state_nxt = state_r;
    launched_nxt = launched_r;
    out_valid_nxt = out_valid_r;
    out_mean_nxt = out_mean_r;
    out_sigma_nxt = out_sigma_r;
    out_level_nxt = out_level_r;
    tsum_nxt = tsum_r;
    tsq_nxt = tsq_r;
    sum2_nxt = sum2_r;
    spread_nxt = spread_r;
    lnum_nxt = lnum_r;
    var_nxt = var_r;
    res_mean_nxt = res_mean_r;
    res_sigma_nxt = res_sigma_r;
    res_level_nxt = res_level_r;
    tot_ready = 1'b0;
    mul_start = 1'b0;
    mul_a = tsq_r;
    mul_b = N_MULT;
    div_start = 1'b0;
    div_n = DN_W'(lnum_r);
    div_d = DIV_LVL;
    sqrt_start = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        tot_ready = 1'b1;
        if (tot_valid) begin
          tsum_nxt = tot_sum;
          tsq_nxt = tot_sum_sq;
          state_nxt = S_SUM2;
        end
      end
      S_SUM2: begin
        mul_a = MA_W'(tsum_r);
        mul_b = MB_W'(tsum_r);
        mul_start = !launched_r && !mul_sts.busy;
        if (mul_start) begin
          launched_nxt = 1'b1;
        end
        if (launched_r && mul_sts.done) begin
          sum2_nxt = mul_prod[SPR_W-1:0];
          launched_nxt = 1'b0;
          state_nxt = S_NSQ;
        end
      end
      S_NSQ: begin
        mul_a = tsq_r;
        mul_b = N_MULT;
        mul_start = !launched_r && !mul_sts.busy;
        if (mul_start) begin
          launched_nxt = 1'b1;
        end
        // The sum of squares scaled by the burst length never falls below the squared sum.
        if (launched_r && mul_sts.done) begin
          spread_nxt = mul_prod[SPR_W-1:0] - sum2_r;
          launched_nxt = 1'b0;
          state_nxt = S_VS;
        end
      end
      S_VS: begin
        mul_a = MA_W'(tsum_r);
        mul_b = MB_W'(vref_r);
        mul_start = !launched_r && !mul_sts.busy;
        if (mul_start) begin
          launched_nxt = 1'b1;
        end
        if (launched_r && mul_sts.done) begin
          lnum_nxt = mul_prod[LN_W-1:0];
          launched_nxt = 1'b0;
          state_nxt = S_DMEAN;
        end
      end
      S_DMEAN: begin
        div_n = DN_W'({tsum_r, 4'b0000});
        div_d = DIV_MEAN;
        div_start = !launched_r && !div_sts.busy;
        if (div_start) begin
          launched_nxt = 1'b1;
        end
        if (launched_r && div_sts.done) begin
          res_mean_nxt = (div_q > DN_W'(MEAN_MAX)) ? MEAN_MAX : div_q[MEAN_W-1:0];
          launched_nxt = 1'b0;
          state_nxt = S_DVAR;
        end
      end
      S_DVAR: begin
        div_n = DN_W'({spread_r, 8'h00});
        div_d = DIV_VAR;
        div_start = !launched_r && !div_sts.busy;
        if (div_start) begin
          launched_nxt = 1'b1;
        end
        if (launched_r && div_sts.done) begin
          var_nxt = div_q;
          launched_nxt = 1'b0;
          state_nxt = S_DLVL;
        end
      end
      S_DLVL: begin
        div_n = DN_W'(lnum_r);
        div_d = DIV_LVL;
        div_start = !launched_r && !div_sts.busy;
        if (div_start) begin
          launched_nxt = 1'b1;
        end
        if (launched_r && div_sts.done) begin
          res_level_nxt = (div_q > DN_W'(LEVEL_MAX)) ? LEVEL_MAX : div_q[LEVEL_W-1:0];
          launched_nxt = 1'b0;
          state_nxt = S_ROOT;
        end
      end
      S_ROOT: begin
        // A zero variance gives a zero root, so no separate zero case is needed.
        sqrt_start = !launched_r && !sqrt_sts.busy;
        if (sqrt_start) begin
          launched_nxt = 1'b1;
        end
        if (launched_r && sqrt_sts.done) begin
          res_sigma_nxt = (sqrt_root > RT_W'(SIGMA_MAX)) ? SIGMA_MAX
                                                          : sqrt_root[SIGMA_W-1:0];
          launched_nxt = 1'b0;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_mean_nxt = res_mean_r;
          out_sigma_nxt = res_sigma_r;
          out_level_nxt = res_level_r;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Sequencer state and the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      launched_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      launched_r <= launched_nxt;
      out_valid_r <= out_valid_nxt;
      out_mean_r <= out_mean_nxt;
      out_sigma_r <= out_sigma_nxt;
      out_level_r <= out_level_nxt;
    end
  end

  // Intermediate results of the burst in flight.
  always_ff @(posedge clk) begin
    tsum_r <= tsum_nxt;
    tsq_r <= tsq_nxt;
    sum2_r <= sum2_nxt;
    spread_r <= spread_nxt;
    lnum_r <= lnum_nxt;
    var_r <= var_nxt;
    res_mean_r <= res_mean_nxt;
    res_sigma_r <= res_sigma_nxt;
    res_level_r <= res_level_nxt;
  end

  // Reference voltage register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vref_r <= VREF_RESET;
    end else if (cfg_wr_en) begin
      vref_r <= cfg_wr_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_mean_x16 = out_mean_r;
  assign out_sigma_x16 = out_sigma_r;
  assign out_level_mv = out_level_r;

endmodule

@@ hw/rtl/smsd_chk.sv @@
module smsd_chk (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [smsd_pkg::MEAN_W-1:0]   out_mean_x16,
  input logic [smsd_pkg::SIGMA_W-1:0]  out_sigma_x16,
  input logic [smsd_pkg::LEVEL_W-1:0]  out_level_mv
);

  // Reset drops any pending result.
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result request visible right after reset");

  // A sample keeps the squaring multiplier busy, so ready drops after each accept.
  a_digit_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("sample accepted while the previous one is still being squared");

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_mean_x16)
      && $stable(out_sigma_x16) && $stable(out_level_mv))
    else $error("result changed or dropped while stalled");

  // A mean below one sixteenth of a count cannot scale to a nonzero level.
  a_zero_mean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_mean_x16 == '0 |-> out_level_mv == '0)
    else $error("nonzero level with zero mean");

endmodule

bind sample_mean_stddev smsd_chk u_smsd_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_mean_x16  (out_mean_x16),
  .out_sigma_x16 (out_sigma_x16),
  .out_level_mv  (out_level_mv)
);

@@ sim/smsd_stats_checker.sv @@
module smsd_stats_checker
  import smsd_pkg::*;
#(
  parameter int SAMPLES = SAMPLES_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  logic [SAMPLE_BITS-1:0] in_sample,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  logic [MEAN_W-1:0]      out_mean_x16,
  input  logic [SIGMA_W-1:0]     out_sigma_x16,
  input  logic [LEVEL_W-1:0]     out_level_mv,
  input  logic                   cfg_wr_en,
  input  logic [VREF_W-1:0]      cfg_wr_data,
  output int                     fail_count,
  output int                     stats_pending,
  output int                     bursts_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [MEAN_W-1:0]  mean_x16;
    logic [SIGMA_W-1:0] sigma_x16;
    logic [LEVEL_W-1:0] level_mv;
  } burst_stats_t;

  logic [SAMPLE_BITS-1:0] burst_samples [SAMPLES];
  int unsigned            burst_fill;
  logic [VREF_W-1:0]      vref_copy;
  burst_stats_t           stats_due [$];
  int                     fails;
  int                     checked;

  // Largest root whose square does not exceed the argument, built bit by bit.
  function automatic longint unsigned floor_root(input longint unsigned v);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= v) begin
        root = trial;
      end
    end
    return root;
  endfunction

  // Saturate a value at the all-ones code of a field of the given width.
  function automatic longint unsigned clamp_to(input longint unsigned v, input int bits);
    longint unsigned top;
    top = (64'd1 << bits) - 1;
    return (v > top) ? top : v;
  endfunction

  // Mean, sample deviation and millivolt level of the burst that was just completed.
  function automatic burst_stats_t compute_burst_stats(input logic [VREF_W-1:0] vref);
    longint unsigned n;
    longint unsigned total;
    longint unsigned squares;
    longint unsigned spread;
    longint unsigned var256;
    burst_stats_t    s;
    n = SAMPLES;
    total = 0;
    squares = 0;
    foreach (burst_samples[k]) begin
      total += burst_samples[k];
      squares += longint'(burst_samples[k]) * longint'(burst_samples[k]);
    end
    spread = n * squares - total * total;
    var256 = (spread * 256) / (n * (n - 1));
    s.mean_x16 = MEAN_W'(clamp_to((total * 16) / n, MEAN_W));
    s.sigma_x16 = (spread == 0) ? '0 : SIGMA_W'(clamp_to(floor_root(var256), SIGMA_W));
    s.level_mv = LEVEL_W'(clamp_to((longint'(vref) * total) / (FULL_SCALE * n), LEVEL_W));
    return s;
  endfunction

  always @(posedge clk) begin
    burst_stats_t want;
    if (!rst_n) begin
      burst_fill = 0;
      vref_copy = VREF_RESET;
      stats_due.delete();
      fails = 0;
      checked = 0;
    end else begin
      // The reference voltage copy follows every register write.
      if (cfg_wr_en) begin
        vref_copy = cfg_wr_data;
      end

      // Compare each delivered result with the oldest burst still owed.
      if (out_valid && out_ready) begin
        if (stats_due.size() == 0) begin
          fails++;
          if (fails <= REPORT_LIMIT) begin
            $display("ERROR: result request with no burst owed: mean %0d sigma %0d level %0d",
                     out_mean_x16, out_sigma_x16, out_level_mv);
          end
        end else begin
          want = stats_due.pop_front();
          checked++;
          if (out_mean_x16 !== want.mean_x16 || out_sigma_x16 !== want.sigma_x16 ||
              out_level_mv !== want.level_mv) begin
            fails++;
            if (fails <= REPORT_LIMIT) begin
              $display("ERROR: burst %0d: mean %0d/%0d sigma %0d/%0d level %0d/%0d (got/want)",
                       checked, out_mean_x16, want.mean_x16, out_sigma_x16,
                       want.sigma_x16, out_level_mv, want.level_mv);
            end
          end
        end
      end

      // Collect accepted samples; the last one of a burst produces an expectation.
      if (in_valid && in_ready) begin
        burst_samples[burst_fill] = in_sample;
        burst_fill++;
        if (burst_fill == SAMPLES) begin
          stats_due.push_back(compute_burst_stats(vref_copy));
          burst_fill = 0;
        end
      end
    end
    fail_count <= fails;
    stats_pending <= stats_due.size();
    bursts_checked <= checked;
  end

endmodule

@@ sim/tb_top.sv @@
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import smsd_pkg::*;

  localparam int PHASES           = 8;
  localparam int BURSTS_PER_PHASE = 15;
  localparam int SETTLE_CYCLES    = 250;
  localparam int CYCLE_LIMIT      = 400000;
  localparam int IN_IDLE_PCT [4]   = '{0, 66, 0, 19};
  localparam int OUT_STALL_PCT [4] = '{0, 0, 66, 19};

  typedef enum {
    BURST_UNIFORM,
    BURST_CONSTANT,
    BURST_RAILS,
    BURST_NEAR_FLAT,
    BURST_NARROW
  } burst_kind_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_ready;
  logic [SAMPLE_BITS-1:0] in_sample;
  logic                   out_valid;
  logic                   out_ready;
  logic [MEAN_W-1:0]      out_mean_x16;
  logic [SIGMA_W-1:0]     out_sigma_x16;
  logic [LEVEL_W-1:0]     out_level_mv;
  logic                   cfg_wr_en;
  logic [VREF_W-1:0]      cfg_wr_data;

  int fail_count;
  int stats_pending;
  int bursts_checked;
  int in_idle_pct;
  int out_stall_pct;
  int samples_sent;
  int cycle_count = 0;

  sample_mean_stddev uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_sample    (in_sample),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_mean_x16 (out_mean_x16),
    .out_sigma_x16(out_sigma_x16),
    .out_level_mv (out_level_mv),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data)
  );

  smsd_stats_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_sample     (in_sample),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_mean_x16  (out_mean_x16),
    .out_sigma_x16 (out_sigma_x16),
    .out_level_mv  (out_level_mv),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .fail_count    (fail_count),
    .stats_pending (stats_pending),
    .bursts_checked(bursts_checked)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // The receiver stalls at random according to the current phase.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= out_stall_pct);
  end

  // Hard stop in case the block hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d bursts still owed", cycle_count,
               stats_pending);
      $display("Verification failed");
      $finish;
    end
  end

  // Offer one sample, idling first at random, and wait until the request is taken.
  task automatic push_sample(input logic [SAMPLE_BITS-1:0] v);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sample <= v;
    do @(posedge clk); while (!in_ready);
    samples_sent++;
  endtask

  // One full burst whose values are shaped by the kind.
  task automatic send_burst(input burst_kind_t kind);
    logic [SAMPLE_BITS-1:0] base;
    logic [SAMPLE_BITS-1:0] v;
    int                     odd_one;
    if ($urandom_range(3) == 0) begin
      base = $urandom_range(1) ? '1 : '0;
    end else begin
      base = SAMPLE_BITS'($urandom_range(FULL_SCALE));
    end
    odd_one = $urandom_range(SAMPLES_DEF - 1);
    for (int k = 0; k < SAMPLES_DEF; k++) begin
      case (kind)
        BURST_CONSTANT: begin
          v = base;
        end
        BURST_RAILS: begin
          v = $urandom_range(1) ? '1 : '0;
        end
        // A single sample one count away gives the smallest nonzero variance.
        BURST_NEAR_FLAT: begin
          v = (k == odd_one) ? (base ^ SAMPLE_BITS'(1)) : base;
        end
        BURST_NARROW: begin
          v = (base & ~SAMPLE_BITS'(15)) | SAMPLE_BITS'($urandom_range(15));
        end
        default: begin
          v = SAMPLE_BITS'($urandom_range(FULL_SCALE));
        end
      endcase
      push_sample(v);
    end
  endtask

  function automatic burst_kind_t pick_burst_kind();
    int r;
    r = $urandom_range(99);
    if (r < 45) return BURST_UNIFORM;
    if (r < 60) return BURST_CONSTANT;
    if (r < 75) return BURST_RAILS;
    if (r < 87) return BURST_NEAR_FLAT;
    return BURST_NARROW;
  endfunction

  // Wait until every owed result has come back, then let the engine settle.
  task automatic wait_drained();
    do @(posedge clk); while (stats_pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_vref(input logic [VREF_W-1:0] v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    logic [VREF_W-1:0] vref_plan [PHASES];
    vref_plan = '{13'd0, 13'd5000, 13'd8191, 13'd1, 13'd3300, 13'd1023, 13'd0, 13'd2500};
    vref_plan[6] = VREF_W'($urandom_range(8191));
    samples_sent = 0;
    in_idle_pct = 0;
    out_stall_pct = 0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_sample <= '0;
    out_ready <= 1'b0;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: a full-scale constant burst at the reset reference voltage.
    for (int k = 0; k < SAMPLES_DEF; k++) begin
      push_sample('1);
    end
    in_valid <= 1'b0;

    // Random bursts under each reference voltage and handshake mode.
    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      write_vref(vref_plan[p]);
      in_idle_pct = IN_IDLE_PCT[p % 4];
      out_stall_pct = OUT_STALL_PCT[p % 4];
      for (int b = 0; b < BURSTS_PER_PHASE; b++) begin
        send_burst(pick_burst_kind());
      end
      in_valid <= 1'b0;
    end

    wait_drained();
    $display("Run covered %0d samples over %0d reference voltages and four handshake modes.",
             samples_sent, PHASES + 1);
    $display("%0d burst results were checked, %0d of them failed.", bursts_checked,
             fail_count);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
